>>> rtl/core/spectrum_bar_led_mapper_core_defines.svh
// assertion macros for the spectrum bar led mapper core
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SPECTRUM_BAR_LED_MAPPER_CORE_DEFINES_SVH
`define SPECTRUM_BAR_LED_MAPPER_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define SBLM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition that must never be seen outside reset
`define SBLM_ASSERT_NEVER(name, cond, msg) \
  `SBLM_ASSERT(name, !(cond), msg)

`endif

>>> rtl/core/sblm_pkg.sv
// shared types, constants and the level quantizer of the spectrum bar led mapper
// no dependencies
`default_nettype none

package sblm_pkg;

  localparam int MAG_W     = 16;
  localparam int COL_IDX_W = 4;
  localparam int LEVEL_W   = 4;
  localparam int LED_IDX_W = 7;
  localparam int COLOR_W   = 24;
  localparam int BIN_CNT_W = 9;
  localparam int NUM_THRESH = 10;

  localparam int DEF_BINS_PER_COLUMN = 31;
  localparam int DEF_NUM_COLUMNS     = 12;
  localparam int DEF_NUM_ROWS        = 10;
  localparam int DEF_FIFO_DEPTH      = 4;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register indexes, taken from paddr[2]
  localparam logic REG_FLOOR_FIRST = 1'b0;
  localparam logic REG_FLOOR_REST  = 1'b1;

  localparam logic [MAG_W-1:0] FLOOR_FIRST_RST = 16'd486;
  localparam logic [MAG_W-1:0] FLOOR_REST_RST  = 16'd128;

  // q8.8 codes of 0.5 .. 31.7, rounded up
  localparam logic [MAG_W-1:0] THRESH [NUM_THRESH] = '{
    16'd128, 16'd308, 16'd589, 16'd999, 16'd1588,
    16'd2407, 16'd3482, 16'd4864, 16'd6656, 16'd8116
  };

  // bottom row first
  localparam logic [COLOR_W-1:0] ROW_COLOR [NUM_THRESH] = '{
    24'hFF0000, 24'hFF7F00, 24'hFFFF00, 24'h7FFF00, 24'h00FF00,
    24'h00FF7F, 24'h00FFFF, 24'h007FFF, 24'h0000FF, 24'h7F00FF
  };

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             frame_start;
  } bin_item_t;

  typedef struct packed {
    logic [LED_IDX_W-1:0] led_index;
    logic [COLOR_W-1:0]   color;
    logic [LEVEL_W-1:0]   bar_level;
    logic                 last;
  } led_write_t;

  // one finished column waiting for the led writer
  typedef struct packed {
    logic [COL_IDX_W-1:0] col;
    logic [MAG_W-1:0]     peak;
  } col_entry_t;

  function automatic logic [LEVEL_W-1:0] quantize(input logic [MAG_W-1:0] peak,
                                                  input logic [MAG_W-1:0] floor_q);
    logic [LEVEL_W-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < NUM_THRESH; i++) begin
      if (peak >= THRESH[i]) lvl = lvl + LEVEL_W'(1);
    end
    if (peak < floor_q) lvl = '0;
    return lvl;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sblm_front.sv
// bin front end: frame and column counting, running peak per column
// depends on sblm_pkg; pushes finished columns into sblm_fifo
`default_nettype none

module sblm_front #(
  parameter int BINS_PER_COLUMN = sblm_pkg::DEF_BINS_PER_COLUMN,
  parameter int NUM_COLUMNS     = sblm_pkg::DEF_NUM_COLUMNS
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  sblm_pkg::bin_item_t    in_item_i,
  output logic                   in_stall_o,
  input  wire                    full_i,
  output logic                   push_o,
  output sblm_pkg::col_entry_t   push_entry_o
);

  localparam int ColW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int BinW = (BINS_PER_COLUMN > 1) ? $clog2(BINS_PER_COLUMN) : 1;
  localparam int CntW = sblm_pkg::BIN_CNT_W;

  logic [CntW-1:0]            bin_cnt_q, bin_cnt_d;
  logic [ColW-1:0]            col_q, col_d;
  logic [BinW-1:0]            bic_q, bic_d;
  logic [sblm_pkg::MAG_W-1:0] peak_q, peak_d, peak_new;
  logic                       done_q, done_d;
  logic                       accept;
  logic                       col_end;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign peak_new   = (in_item_i.magnitude > peak_q) ? in_item_i.magnitude : peak_q;
  assign col_end    = (bic_q == BinW'(BINS_PER_COLUMN - 1));

  always_comb begin
    bin_cnt_d    = bin_cnt_q;
    col_d        = col_q;
    bic_d        = bic_q;
    peak_d       = peak_q;
    done_d       = done_q;
    push_o       = 1'b0;
    push_entry_o.col  = sblm_pkg::COL_IDX_W'(col_q);
    push_entry_o.peak = peak_new;
    if (accept) begin
      if (in_item_i.frame_start || bin_cnt_q == '0) begin
        // dc bin of a new frame
        bin_cnt_d = CntW'(1);
        col_d     = '0;
        bic_d     = '0;
        peak_d    = '0;
        done_d    = 1'b0;
      end else begin
        if (bin_cnt_q != '1) bin_cnt_d = bin_cnt_q + CntW'(1);
        if (!done_q) begin
          if (col_end) begin
            push_o = 1'b1;
            peak_d = '0;
            bic_d  = '0;
            if (col_q == ColW'(NUM_COLUMNS - 1)) begin
              done_d = 1'b1;
            end else begin
              col_d = col_q + ColW'(1);
            end
          end else begin
            peak_d = peak_new;
            bic_d  = bic_q + BinW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_cnt_q <= '0;
      col_q     <= '0;
      bic_q     <= '0;
      peak_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      bin_cnt_q <= bin_cnt_d;
      col_q     <= col_d;
      bic_q     <= bic_d;
      peak_q    <= peak_d;
      done_q    <= done_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sblm_fifo.sv
// small column queue between the bin front end and the led writer
// depends on sblm_pkg for the entry type
`default_nettype none

`include "spectrum_bar_led_mapper_core_defines.svh"

module sblm_fifo #(
  parameter int Depth = sblm_pkg::DEF_FIFO_DEPTH
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  sblm_pkg::col_entry_t   push_entry_i,
  output logic                   full_o,
  input  wire                    pop_i,
  output sblm_pkg::col_entry_t   head_o,
  output logic                   empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sblm_pkg::col_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) count_d = count_q + CntW'(1);
    if (!push_i && pop_i) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `SBLM_ASSERT(a_count_bound, count_q <= CntW'(Depth), "column queue count above depth")
  `SBLM_ASSERT_NEVER(a_push_full, push_i && full_o, "push into full column queue")
  `SBLM_ASSERT_NEVER(a_pop_empty, pop_i && empty_o, "pop from empty column queue")
  `SBLM_ASSERT(a_count_up, push_i && !pop_i |=> count_q == $past(count_q) + CntW'(1), "push lost")

endmodule

`default_nettype wire

>>> rtl/core/sblm_back.sv
// led writer: quantizes a queued column and emits one led write per row
// depends on sblm_pkg; pops from sblm_fifo
`default_nettype none

module sblm_back #(
  parameter int NUM_COLUMNS = sblm_pkg::DEF_NUM_COLUMNS,
  parameter int NUM_ROWS    = sblm_pkg::DEF_NUM_ROWS
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              empty_i,
  input  sblm_pkg::col_entry_t             head_i,
  output logic                             pop_o,
  input  wire [sblm_pkg::MAG_W-1:0]        floor_first_i,
  input  wire [sblm_pkg::MAG_W-1:0]        floor_rest_i,
  output logic                             out_valid_o,
  output sblm_pkg::led_write_t             out_item_o,
  input  wire                              out_stall_i
);

  localparam int RowW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int PosW = sblm_pkg::LED_IDX_W + 1;

  logic                                busy_q;
  logic [RowW-1:0]                     row_q;
  logic [sblm_pkg::COL_IDX_W-1:0]      col_q;
  logic [sblm_pkg::LEVEL_W-1:0]        lvl_q;
  logic                                out_valid_q;
  sblm_pkg::led_write_t                out_q;
  sblm_pkg::led_write_t                wr_d;
  logic                                adv;
  logic [sblm_pkg::MAG_W-1:0]          floor_sel;
  logic [PosW-1:0]                     pos;

  assign pop_o     = !busy_q && !empty_i;
  assign adv       = busy_q && (!out_valid_q || !out_stall_i);
  assign floor_sel = (head_i.col == '0) ? floor_first_i : floor_rest_i;

  // serpentine: odd rows run right to left
  assign pos = PosW'(row_q) * PosW'(NUM_COLUMNS)
             + (row_q[0] ? PosW'(NUM_COLUMNS - 1) - PosW'(col_q) : PosW'(col_q));

  always_comb begin
    wr_d.led_index = pos[sblm_pkg::LED_IDX_W-1:0];
    wr_d.color     = (sblm_pkg::LEVEL_W'(row_q) < lvl_q) ? sblm_pkg::ROW_COLOR[row_q] : '0;
    wr_d.bar_level = lvl_q;
    wr_d.last      = (row_q == RowW'(NUM_ROWS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        row_q  <= '0;
        col_q  <= head_i.col;
        lvl_q  <= sblm_pkg::quantize(head_i.peak, floor_sel);
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        if (wr_d.last) begin
          busy_q <= 1'b0;
        end else begin
          row_q <= row_q + RowW'(1);
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= wr_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/core/spectrum_bar_led_mapper_core.sv
// top level of the spectrum bar led mapper: apb registers, front end, queue, led writer
// depends on sblm_pkg, sblm_front, sblm_fifo and sblm_back
`default_nettype none

// usage
//   input channel: one fft bin per transaction (magnitude q8.8, frame_start on bin 0),
//   taken whenever in_valid_i is high and in_stall_o is low; one bin per cycle sustained
//   output channel: one led write per transaction, ten (NUM_ROWS) per finished column,
//   led_index in serpentine order, color 0 for rows at or above the level
//   order: a column's last bin is taken with its queue push; the column is then popped and
//   quantized, and its first write enters the output register and becomes valid
//   the led writer pops a column only while idle and then writes its rows; finished columns
//   wait in a FIFO_DEPTH column queue, and in_stall_o rises only while that queue is full
//   when out_stall_i is high the pending write holds, the writer pauses, the queue
//   absorbs further columns and the input keeps flowing until the queue fills
//   apb: noise_floor_first at 0x0, noise_floor_rest at 0x4, 16 bits used; write only
//   while idle; pready is always high
//   reset: counters, peak and queue clear, floors return to 1.9 and 0.5; the first bin
//   after reset is treated as the dc bin of a frame

module spectrum_bar_led_mapper_core #(
  parameter int BINS_PER_COLUMN = sblm_pkg::DEF_BINS_PER_COLUMN,
  parameter int NUM_COLUMNS     = sblm_pkg::DEF_NUM_COLUMNS,
  parameter int NUM_ROWS        = sblm_pkg::DEF_NUM_ROWS,
  parameter int FIFO_DEPTH      = sblm_pkg::DEF_FIFO_DEPTH
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // bin input
  input  wire                                in_valid_i,
  input  sblm_pkg::bin_item_t                in_item_i,
  output logic                               in_stall_o,
  // led write output
  output logic                               out_valid_o,
  output sblm_pkg::led_write_t               out_item_o,
  input  wire                                out_stall_i,
  // register port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [sblm_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire [sblm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sblm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  // noise floor registers
  logic [sblm_pkg::MAG_W-1:0] floor_first_q, floor_first_d;
  logic [sblm_pkg::MAG_W-1:0] floor_rest_q, floor_rest_d;
  logic                       reg_wr;
  logic                       reg_sel;

  // front to queue to back
  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 empty;
  sblm_pkg::col_entry_t push_entry;
  sblm_pkg::col_entry_t head;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    floor_first_d = floor_first_q;
    floor_rest_d  = floor_rest_q;
    if (reg_wr && reg_sel == sblm_pkg::REG_FLOOR_FIRST) begin
      floor_first_d = pwdata[sblm_pkg::MAG_W-1:0];
    end
    if (reg_wr && reg_sel == sblm_pkg::REG_FLOOR_REST) begin
      floor_rest_d = pwdata[sblm_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_first_q <= sblm_pkg::FLOOR_FIRST_RST;
      floor_rest_q  <= sblm_pkg::FLOOR_REST_RST;
    end else begin
      floor_first_q <= floor_first_d;
      floor_rest_q  <= floor_rest_d;
    end
  end

  // read back, upper bits zero (paddr[1:0] ignored, word aligned map)
  assign prdata = (reg_sel == sblm_pkg::REG_FLOOR_FIRST)
                ? sblm_pkg::APB_DATA_W'(floor_first_q)
                : sblm_pkg::APB_DATA_W'(floor_rest_q);

  // bin counting and running peak, one bin per cycle while the queue is not full
  sblm_front #(
    .BINS_PER_COLUMN (BINS_PER_COLUMN),
    .NUM_COLUMNS     (NUM_COLUMNS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_stall_o   (in_stall_o),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // finished columns: index and peak
  sblm_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty)
  );

  // quantize on pop, then one row per cycle into the output register, held by out_stall_i
  sblm_back #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .floor_first_i (floor_first_q),
    .floor_rest_i  (floor_rest_q),
    .out_valid_o   (out_valid_o),
    .out_item_o    (out_item_o),
    .out_stall_i   (out_stall_i)
  );

endmodule

`default_nettype wire
